/* hdl/tthi_pkg.sv */
// Shared types and fixed constants of the text token hash indexer.
// No dependencies; imported by every other file but tthi_fifo.
package tthi_pkg;

	localparam int BKT_W   = 10;
	localparam int KIND_W  = 2;
	localparam int CHARS_W = 3;
	localparam int OFF_W   = 32;
	localparam int BYTE_W  = 8;

	localparam int HASH_SEED = 371;
	// h*31 is formed as h*32 - h: five modular doublings
	localparam int MUL_SHIFTS = 5;

	localparam logic [KIND_W-1:0] KIND_WORD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GRAM   = 2'd2;

	// open run class
	localparam logic [1:0] CLS_NONE   = 2'd0;
	localparam logic [1:0] CLS_LETTER = 2'd1;
	localparam logic [1:0] CLS_DIGIT  = 2'd2;

	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
	localparam logic [BYTE_W-1:0] CASE_GAP   = 8'h20;
	localparam logic [BYTE_W-1:0] HIGH_FIRST = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF7;

	localparam logic [1:0] TAIL_NONE = 2'd0;
	localparam logic [1:0] TAIL_ONE  = 2'd1;
	localparam logic [1:0] TAIL_TWO  = 2'd2;
	localparam logic [1:0] TAIL_THREE = 2'd3;

	typedef struct packed {
		logic [BKT_W-1:0]   bucket;
		logic [KIND_W-1:0]  kind;
		logic [CHARS_W-1:0] chars;
	} tok_t;

	function automatic logic [KIND_W-1:0] cls_kind(input logic [1:0] cls);
		logic [KIND_W-1:0] k;
		case (cls)
			CLS_LETTER: k = KIND_WORD;
			CLS_DIGIT:  k = KIND_NUMBER;
			default:    k = KIND_WORD;
		endcase
		return k;
	endfunction

endpackage

/* hdl/tthi_if.sv */
// Channel interfaces of the text token hash indexer: text bytes in, postings out.
// Uses tthi_pkg for field widths.
interface tthi_text_if;
	import tthi_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic [OFF_W-1:0]  doc_offset;
	logic              end_of_doc;

	modport source (output valid, text_byte, doc_offset, end_of_doc, input ready);
	modport sink   (input valid, text_byte, doc_offset, end_of_doc, output ready);
endinterface

interface tthi_post_if;
	import tthi_pkg::*;
	logic               valid;
	logic               ready;
	logic [BKT_W-1:0]   bucket;
	logic [KIND_W-1:0]  token_kind;
	logic [CHARS_W-1:0] gram_chars;
	logic [OFF_W-1:0]   posting_offset;
	logic               last_of_run;

	modport source (output valid, bucket, token_kind, gram_chars, posting_offset,
		last_of_run, input ready);
	modport sink   (input valid, bucket, token_kind, gram_chars, posting_offset,
		last_of_run, output ready);
endinterface

/* hdl/tthi_front.sv */
// Front end: takes text bytes, tracks runs and n-gram lanes, builds one token record per byte.
// Depends on tthi_pkg and tthi_text_if.
module tthi_front #(
	parameter int BUCKETS  = 1024,
	parameter int GRAM_MAX = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tthi_text_if.sink                           text,
	input  logic                                q_full,
	output logic                                push,
	output logic [tthi_pkg::OFF_W-1:0]          rec_off,
	output logic [GRAM_MAX+1:0]                 rec_mask,
	output tthi_pkg::tok_t [GRAM_MAX+1:0]       rec_toks
);
	import tthi_pkg::*;

	localparam int HW     = $clog2(BUCKETS);
	localparam int CW     = $clog2(GRAM_MAX + 1);
	localparam int SEED_I = HASH_SEED % BUCKETS;
	localparam logic [HW-1:0] SEED = SEED_I[HW-1:0];
	localparam logic [HW:0]   BK   = BUCKETS[HW:0];
	localparam logic [CW-1:0] GMAX = GRAM_MAX[CW-1:0];

	// (h*31 + c) mod BUCKETS with cm = c mod BUCKETS; compare-subtract steps only
	function automatic logic [HW-1:0] mix(input logic [HW-1:0] h, input logic [HW-1:0] cm);
		logic [HW:0] x;
		logic [HW:0] y;
		x = {1'b0, h};
		for (int i = 0; i < MUL_SHIFTS; i++) begin
			x = {x[HW-1:0], 1'b0};
			if (x >= BK) begin
				x = x - BK;
			end
		end
		y = x + BK - {1'b0, h};
		if (y >= BK) begin
			y = y - BK;
		end
		y = y + {1'b0, cm};
		if (y >= BK) begin
			y = y - BK;
		end
		return y[HW-1:0];
	endfunction

	function automatic logic [HW-1:0] byte_mod(input logic [BYTE_W-1:0] c);
		logic [HW:0] r;
		r = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			r = {r[HW-1:0], c[i]};
			if (r >= BK) begin
				r = r - BK;
			end
		end
		return r[HW-1:0];
	endfunction

	logic [HW-1:0] run_hash_q;
	logic [1:0]    run_cls_q;
	logic [1:0]    left_q;
	logic [GRAM_MAX-1:0]         gopen_q;
	logic [GRAM_MAX-1:0][CW-1:0] gcnt_q;
	logic [GRAM_MAX-1:0][HW-1:0] ghash_q;

	logic [BYTE_W-1:0] c;
	logic [HW-1:0]     cm;
	logic              accept, bnd, eod, done, close_a, close_b, shift;
	logic [1:0]        cls, cls_mid, left_nx;
	logic [HW-1:0]     hash_mid;
	logic [GRAM_MAX-1:0]         opn, op;
	logic [GRAM_MAX-1:0][CW-1:0] cnt1;
	logic [GRAM_MAX-1:0][HW-1:0] h1;

	assign text.ready = !q_full;
	assign accept     = text.valid && text.ready;
	assign eod        = text.end_of_doc;
	assign rec_off    = text.doc_offset;
	assign push       = accept && (rec_mask != '0);

	always_comb begin
		c = text.text_byte;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			c = c + CASE_GAP;
		end
		cm  = byte_mod(c);
		bnd = (left_q == TAIL_NONE);

		cls = CLS_NONE;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			cls = CLS_LETTER;
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			cls = CLS_DIGIT;
		end

		close_a  = bnd && (run_cls_q != CLS_NONE) && (cls != run_cls_q);
		cls_mid  = bnd ? cls : run_cls_q;
		hash_mid = run_hash_q;
		if (bnd && cls != CLS_NONE) begin
			hash_mid = mix((run_cls_q == cls) ? run_hash_q : SEED, cm);
		end
		close_b = eod && (cls_mid != CLS_NONE);

		left_nx = TAIL_NONE;
		if (!bnd) begin
			left_nx = left_q - 2'd1;
		end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
			left_nx = TAIL_ONE;
		end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
			left_nx = TAIL_TWO;
		end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
			left_nx = TAIL_THREE;
		end
		done = (left_nx == TAIL_NONE) || eod;

		// lanes are kept oldest first and packed; a new track goes to the first free lane
		for (int j = 0; j < GRAM_MAX; j++) begin
			opn[j] = bnd && (c >= HIGH_FIRST) && !gopen_q[j] && ((j == 0) || gopen_q[(j == 0) ? 0 : j - 1]);
			op[j]  = gopen_q[j] || opn[j];
			h1[j]  = mix(opn[j] ? SEED : ghash_q[j], cm);
			cnt1[j] = (opn[j] ? '0 : gcnt_q[j]) + CW'(done);
		end
		// only the oldest lane can reach the full length
		shift = done && op[0] && (cnt1[0] == GMAX);

		rec_mask[0] = close_a;
		rec_toks[0].bucket = BKT_W'(run_hash_q);
		rec_toks[0].kind   = cls_kind(run_cls_q);
		rec_toks[0].chars  = '0;
		rec_mask[1] = close_b;
		rec_toks[1].bucket = BKT_W'(hash_mid);
		rec_toks[1].kind   = cls_kind(cls_mid);
		rec_toks[1].chars  = '0;
		for (int j = 0; j < GRAM_MAX; j++) begin
			rec_mask[j+2] = done && op[j];
			rec_toks[j+2].bucket = BKT_W'(h1[j]);
			rec_toks[j+2].kind   = KIND_GRAM;
			rec_toks[j+2].chars  = CHARS_W'(cnt1[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hash_q <= SEED;
			run_cls_q  <= CLS_NONE;
			left_q     <= TAIL_NONE;
			gopen_q    <= '0;
			gcnt_q     <= '0;
			ghash_q    <= {GRAM_MAX{SEED}};
		end else if (accept) begin
			if (eod) begin
				run_hash_q <= SEED;
				run_cls_q  <= CLS_NONE;
				left_q     <= TAIL_NONE;
				gopen_q    <= '0;
				gcnt_q     <= '0;
				ghash_q    <= {GRAM_MAX{SEED}};
			end else begin
				run_hash_q <= hash_mid;
				run_cls_q  <= cls_mid;
				left_q     <= left_nx;
				for (int j = 0; j < GRAM_MAX; j++) begin
					if (shift) begin
						if (j < GRAM_MAX - 1) begin
							gopen_q[j] <= op[(j < GRAM_MAX - 1) ? j + 1 : j];
							gcnt_q[j]  <= cnt1[(j < GRAM_MAX - 1) ? j + 1 : j];
							ghash_q[j] <= h1[(j < GRAM_MAX - 1) ? j + 1 : j];
						end else begin
							gopen_q[j] <= 1'b0;
							gcnt_q[j]  <= '0;
							ghash_q[j] <= SEED;
						end
					end else begin
						gopen_q[j] <= op[j];
						gcnt_q[j]  <= cnt1[j];
						ghash_q[j] <= h1[j];
					end
				end
			end
		end
	end

endmodule

/* hdl/tthi_fifo.sv */
// Record queue between front and back end; registers only, one write and one head read.
// No dependencies; word width and depth come in as parameters.
module tthi_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0]   DEPTH_C = DEPTH[AW:0];
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full    = (cnt_q == DEPTH_C);
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/tthi_back.sv */
// Back end: walks the head record's token slots and sends one posting word per cycle while post.ready allows.
// Depends on tthi_pkg and tthi_post_if.
module tthi_back #(
	parameter int NSLOT = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	input  logic [tthi_pkg::OFF_W-1:0]     rec_off,
	input  logic [NSLOT-1:0]               rec_mask,
	input  tthi_pkg::tok_t [NSLOT-1:0]     rec_toks,
	output logic                           pop,
	tthi_post_if.source                    post
);
	import tthi_pkg::*;

	localparam int SW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	logic [NSLOT-1:0] sent_q;
	logic             vld_q;
	tok_t             tok_q;
	logic [OFF_W-1:0] off_q;
	logic             last_q;

	logic [NSLOT-1:0] rem, pick;
	logic [SW-1:0]    sel;
	logic             last, load;

	always_comb begin
		rem  = rec_mask & ~sent_q;
		pick = rem & (~rem + 1'b1);
		sel  = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (rem[i]) begin
				sel = SW'(i);
			end
		end
		last = ((rem & ~pick) == '0);
		load = !empty && (!vld_q || post.ready);
		pop  = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			sent_q <= '0;
		end else begin
			if (load) begin
				vld_q  <= 1'b1;
				sent_q <= last ? '0 : (sent_q | pick);
			end else if (post.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= rec_toks[sel];
			off_q  <= rec_off;
			last_q <= last;
		end
	end

	assign post.valid          = vld_q;
	assign post.bucket         = tok_q.bucket;
	assign post.token_kind     = tok_q.kind;
	assign post.gram_chars     = tok_q.chars;
	assign post.posting_offset = off_q;
	assign post.last_of_run    = last_q;

endmodule

/* hdl/text_token_hash_indexer.sv */
// Text token hash indexer, top level. Uses tthi_pkg, tthi_if, tthi_front, tthi_fifo, tthi_back.
// text: one document byte per word with its doc_offset and end_of_doc (set on the final byte).
// post: one posting per word - bucket, token_kind (word, number, n-gram), gram_chars,
//   posting_offset and last_of_run, which marks the final posting caused by a byte.
// A byte can cause zero to GRAM_MAX+1 postings, always in order: a run closed by a class
//   change, a run closed by end_of_doc, then n-grams from oldest track to newest.
// Throughput: the front end takes one byte per cycle while the record queue has room; the
//   back end sends one posting per cycle while post.ready is high, so a byte's postings go
//   out in turn; a byte with none adds no record. The output port sets the sustained rate.
// Path: with the queue empty, a byte's record is written into the queue when the byte is
//   taken; the back end then loads its first posting into the output register behind post.valid.
// Stall: if post.ready is low the output register holds, the queue fills (QDEPTH records)
//   and then text.ready drops; nothing is lost or repeated.
// Reset: arst_n clears run, n-gram lanes and the queue; the block accepts at once.
// end_of_doc flushes the open run and every open track, then returns to the reset state.
module text_token_hash_indexer #(
	parameter int BUCKETS  = 1024,
	parameter int GRAM_MAX = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	tthi_text_if.sink   text,
	tthi_post_if.source post
);
	import tthi_pkg::*;

	localparam int NSLOT  = GRAM_MAX + 2;
	localparam int QDEPTH = 4;
	localparam int RECW   = OFF_W + NSLOT + NSLOT * $bits(tok_t);

	// record written by the front end for each byte that causes postings
	logic                   f_push;
	logic [OFF_W-1:0]       f_off;
	logic [NSLOT-1:0]       f_mask;
	tok_t [NSLOT-1:0]       f_toks;

	// head record seen by the back end
	logic                   q_full, q_empty, b_pop;
	logic [RECW-1:0]        q_rd;
	logic [OFF_W-1:0]       h_off;
	logic [NSLOT-1:0]       h_mask;
	tok_t [NSLOT-1:0]       h_toks;

	tthi_front #(
		.BUCKETS  (BUCKETS),
		.GRAM_MAX (GRAM_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.q_full   (q_full),
		.push     (f_push),
		.rec_off  (f_off),
		.rec_mask (f_mask),
		.rec_toks (f_toks)
	);

	tthi_fifo #(
		.WIDTH (RECW),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data ({f_off, f_mask, f_toks}),
		.pop     (b_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign {h_off, h_mask, h_toks} = q_rd;

	tthi_back #(
		.NSLOT (NSLOT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.rec_off  (h_off),
		.rec_mask (h_mask),
		.rec_toks (h_toks),
		.pop      (b_pop),
		.post     (post)
	);

endmodule

/* test/tb.sv */
// Self-checking bench for text_token_hash_indexer: directed byte table, then random documents.
// Depends on tthi_pkg and the tthi_text_if / tthi_post_if channel interfaces from hdl/.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tthi_pkg::*;

	localparam int PERIOD       = 10;
	localparam int RESET_CYCLES = 12;
	localparam int BUCKETS      = 1024;
	localparam int GRAMS        = 4;
	localparam int HASH_MUL     = 31;
	localparam int RANDOM_ITEMS = 125;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [BKT_W-1:0] SEED10 = BKT_W'(HASH_SEED % BUCKETS);

	typedef struct packed {
		logic [BKT_W-1:0]   bucket;
		logic [KIND_W-1:0]  kind;
		logic [CHARS_W-1:0] chars;
		logic [OFF_W-1:0]   offset;
		logic               last;
	} posting_t;

	// one row of the directed table; typed rows carry their single posting (or none)
	typedef struct packed {
		logic [BYTE_W-1:0]  ch;
		logic [OFF_W-1:0]   offset;
		logic               eod;
		logic               typed;
		logic [2:0]         count;
		logic [BKT_W-1:0]   bucket;
		logic [KIND_W-1:0]  kind;
		logic [CHARS_W-1:0] chars;
	} stim_row_t;

	localparam int DIRECTED_N = 25;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		// single-byte documents straight out of reset: answers known by hand
		'{8'h61, 32'h0000_0000, 1'b1, 1'b1, 3'd1, 10'd334, KIND_WORD,   3'd0},
		'{8'h30, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd1, 10'd285, KIND_NUMBER, 3'd0},
		'{8'hFF, 32'h0000_0000, 1'b1, 1'b1, 3'd1, 10'd492, KIND_GRAM,   3'd1},
		'{8'h00, 32'h0000_0001, 1'b1, 1'b1, 3'd0, 10'd0,   KIND_WORD,   3'd0},
		'{8'h5A, 32'h8000_0000, 1'b1, 1'b1, 3'd1, 10'd359, KIND_WORD,   3'd0},
		// "Hi42 " : word closed by a digit, number closed by a space
		'{8'h48, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h69, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h34, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h32, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h20, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		// two-, three- and four-byte characters stacking n-gram tracks
		'{8'hC3, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'hA9, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'hE2, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h82, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'hAC, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'hF0, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h9F, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h98, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h80, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		// ASCII letter fills the oldest track; then class change plus end of doc
		'{8'h78, 32'h1234_5678, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h37, 32'h1234_5678, 1'b1, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		// stray bytes, then a lead byte cut short by end of doc
		'{8'hF8, 32'h0F0F_A5A5, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'hBF, 32'h0F0F_A5A5, 1'b0, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'hE0, 32'h0F0F_A5A5, 1'b1, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0},
		'{8'h7F, 32'h5A5A_0F0F, 1'b1, 1'b0, 3'd0, 10'd0, KIND_WORD, 3'd0}
	};

	logic clk;
	logic arst_n;

	tthi_text_if text_ch ();
	tthi_post_if post_ch ();

	text_token_hash_indexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.post   (post_ch)
	);

	always #(PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Indexer predictor: run hash, n-gram tracks, UTF-8 framing
	// ---------------------------------------------------------------
	logic [BKT_W-1:0]   run_hash;
	logic [1:0]         run_cls;
	logic [BKT_W-1:0]   gram_hash [GRAMS];
	logic [CHARS_W-1:0] gram_cnt  [GRAMS];
	logic               gram_on   [GRAMS];
	logic [1:0]         tail_left;

	posting_t step_posts [$];   // postings caused by the byte just taken
	posting_t want_posts [$];   // postings still owed by the block

	int  mismatches;
	int  cycles;
	bit  steady;                // both sides stop idling while set

	function automatic logic [BKT_W-1:0] mix31(input logic [BKT_W-1:0] h,
		input logic [BYTE_W-1:0] c);
		return BKT_W'((int'(h) * HASH_MUL + int'(c)) % BUCKETS);
	endfunction

	task automatic clear_index();
		int i;
		run_hash  = SEED10;
		run_cls   = CLS_NONE;
		tail_left = TAIL_NONE;
		for (i = 0; i < GRAMS; i++) begin
			gram_hash[i] = SEED10;
			gram_cnt[i]  = '0;
			gram_on[i]   = 1'b0;
		end
	endtask

	task automatic note_posting(input logic [BKT_W-1:0] bucket, input logic [KIND_W-1:0] kind,
		input int chars, input logic [OFF_W-1:0] offset);
		posting_t p;
		p.bucket = bucket;
		p.kind   = kind;
		p.chars  = CHARS_W'(chars);
		p.offset = offset;
		p.last   = 1'b0;
		step_posts.push_back(p);
	endtask

	// Advances the predictor by one byte; fills step_posts in output order.
	task automatic index_byte(input logic [BYTE_W-1:0] raw, input logic [OFF_W-1:0] offset,
		input logic eod);
		logic [BYTE_W-1:0] c;
		logic [1:0]        cls;
		bit                opened;
		int                i, k;
		c = raw;
		step_posts.delete();
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			c = c + CASE_GAP;
		end
		if (tail_left == TAIL_NONE) begin
			cls = CLS_NONE;
			if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
				cls = CLS_LETTER;
			end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
				cls = CLS_DIGIT;
			end
			// class change closes the open run before this byte joins anything
			if (run_cls != CLS_NONE && cls != run_cls) begin
				note_posting(run_hash, (run_cls == CLS_DIGIT) ? KIND_NUMBER : KIND_WORD, 0,
					offset);
				run_cls = CLS_NONE;
			end
			if (cls != CLS_NONE) begin
				if (run_cls == CLS_NONE) begin
					run_hash = SEED10;
				end
				run_hash = mix31(run_hash, c);
				run_cls  = cls;
			end
			// any high byte at a boundary opens a track in the first free slot
			if (c >= HIGH_FIRST) begin
				opened = 1'b0;
				for (i = 0; i < GRAMS; i++) begin
					if (!opened && !gram_on[i]) begin
						gram_on[i]   = 1'b1;
						gram_cnt[i]  = '0;
						gram_hash[i] = SEED10;
						opened       = 1'b1;
					end
				end
				if (c >= LEAD2_LO && c <= LEAD2_HI) begin
					tail_left = TAIL_ONE;
				end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
					tail_left = TAIL_TWO;
				end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
					tail_left = TAIL_THREE;
				end
			end
		end else begin
			tail_left = tail_left - 2'd1;
		end

		if (eod && run_cls != CLS_NONE) begin
			note_posting(run_hash, (run_cls == CLS_DIGIT) ? KIND_NUMBER : KIND_WORD, 0, offset);
			run_cls = CLS_NONE;
		end

		for (i = 0; i < GRAMS; i++) begin
			if (gram_on[i]) begin
				gram_hash[i] = mix31(gram_hash[i], c);
			end
		end

		// character complete (or cut off by end of doc): longest n-gram first
		if (tail_left == TAIL_NONE || eod) begin
			for (i = 0; i < GRAMS; i++) begin
				if (gram_on[i]) begin
					gram_cnt[i] = gram_cnt[i] + 1'b1;
				end
			end
			for (k = GRAMS; k >= 1; k--) begin
				for (i = 0; i < GRAMS; i++) begin
					if (gram_on[i] && int'(gram_cnt[i]) == k) begin
						note_posting(gram_hash[i], KIND_GRAM, k, offset);
						if (k >= GRAMS) begin
							gram_on[i] = 1'b0;
						end
					end
				end
			end
		end

		if (step_posts.size() > 0) begin
			step_posts[step_posts.size() - 1].last = 1'b1;
		end
		if (eod) begin
			clear_index();
		end
	endtask

	// ---------------------------------------------------------------
	// Text side: one word per call, optional idle cycle in front
	// ---------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [OFF_W-1:0] offset,
		input logic eod);
		if (!steady && $urandom_range(0, 99) < 10) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid      <= 1'b1;
		text_ch.text_byte  <= b;
		text_ch.doc_offset <= offset;
		text_ch.end_of_doc <= eod;
		do @(posedge clk); while (text_ch.ready !== 1'b1);
	endtask

	task automatic feed(input logic [BYTE_W-1:0] b, input logic [OFF_W-1:0] offset,
		input logic eod);
		int m;
		send_byte(b, offset, eod);
		index_byte(b, offset, eod);
		for (m = 0; m < step_posts.size(); m++) begin
			want_posts.push_back(step_posts[m]);
		end
	endtask

	// Random document: mostly well-formed letters, digits and UTF-8 characters,
	// with stray bytes, cut-short characters and raw noise mixed in.
	logic [BYTE_W-1:0] doc_bytes [$];

	task automatic build_doc();
		int n_chars, pick, len, tails;
		doc_bytes.delete();
		n_chars = $urandom_range(1, 12);
		repeat (n_chars) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				doc_bytes.push_back($urandom_range(0, 1) ?
					BYTE_W'($urandom_range(CH_UPPER_Z, CH_UPPER_A)) :
					BYTE_W'($urandom_range(CH_LOWER_Z, CH_LOWER_A)));
			end else if (pick < 37) begin
				doc_bytes.push_back(BYTE_W'($urandom_range(CH_DIGIT_9, CH_DIGIT_0)));
			end else if (pick < 47) begin
				doc_bytes.push_back(BYTE_W'($urandom_range(0, 127)));
			end else if (pick < 85) begin
				len = $urandom_range(2, 4);
				case (len)
					2:       doc_bytes.push_back(BYTE_W'($urandom_range(LEAD2_HI, LEAD2_LO)));
					3:       doc_bytes.push_back(BYTE_W'($urandom_range(LEAD3_HI, LEAD3_LO)));
					default: doc_bytes.push_back(BYTE_W'($urandom_range(LEAD4_HI, LEAD4_LO)));
				endcase
				// now and then a character is cut short
				tails = ($urandom_range(0, 99) < 10) ? $urandom_range(0, len - 2) : len - 1;
				repeat (tails) doc_bytes.push_back(BYTE_W'($urandom_range(8'hBF, 8'h80)));
			end else if (pick < 92) begin
				doc_bytes.push_back($urandom_range(0, 1) ? BYTE_W'($urandom_range(8'hBF, 8'h80)) :
					BYTE_W'($urandom_range(8'hFF, 8'hF8)));
			end else begin
				doc_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Posting side: random stalls, compare against the oldest owed posting
	// ---------------------------------------------------------------
	task automatic flag_field(input string field, input logic [OFF_W-1:0] want,
		input logic [OFF_W-1:0] got);
		mismatches++;
		$display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
	endtask

	always @(posedge clk) begin : take_posting
		posting_t want;
		if (post_ch.valid === 1'b1 && post_ch.ready === 1'b1) begin
			if (want_posts.size() == 0) begin
				mismatches++;
				$display("%0t ns: posting expected none got bucket %0h kind %0h", $time,
					post_ch.bucket, post_ch.token_kind);
			end else begin
				want = want_posts.pop_front();
				if (post_ch.bucket !== want.bucket)
					flag_field("bucket", OFF_W'(want.bucket), OFF_W'(post_ch.bucket));
				if (post_ch.token_kind !== want.kind)
					flag_field("token_kind", OFF_W'(want.kind), OFF_W'(post_ch.token_kind));
				if (post_ch.gram_chars !== want.chars)
					flag_field("gram_chars", OFF_W'(want.chars), OFF_W'(post_ch.gram_chars));
				if (post_ch.posting_offset !== want.offset)
					flag_field("posting_offset", want.offset, post_ch.posting_offset);
				if (post_ch.last_of_run !== want.last)
					flag_field("last_of_run", OFF_W'(want.last), OFF_W'(post_ch.last_of_run));
			end
		end
		post_ch.ready <= arst_n && (steady || $urandom_range(0, 99) >= 10);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		stim_row_t        row;
		posting_t         hand;
		logic [OFF_W-1:0] doc_off;
		int               r, j, random_sent;

		clk                = 1'b0;
		arst_n             = 1'b0;
		steady             = 1'b0;
		mismatches         = 0;
		cycles             = 0;
		random_sent        = 0;
		text_ch.valid      = 1'b0;
		text_ch.text_byte  = '0;
		text_ch.doc_offset = '0;
		text_ch.end_of_doc = 1'b0;
		post_ch.ready      = 1'b0;
		clear_index();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows are checked against their hand-worked posting
		for (r = 0; r < DIRECTED_N; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.typed) begin
				send_byte(row.ch, row.offset, row.eod);
				index_byte(row.ch, row.offset, row.eod);  // keeps predictor state in step
				if (row.count != 3'd0) begin
					hand.bucket = row.bucket;
					hand.kind   = row.kind;
					hand.chars  = row.chars;
					hand.offset = row.offset;
					hand.last   = 1'b1;
					want_posts.push_back(hand);
				end
			end else begin
				feed(row.ch, row.offset, row.eod);
			end
		end

		// random documents; a stretch in the middle runs with no idling
		while (random_sent < RANDOM_ITEMS) begin
			build_doc();
			doc_off = $urandom();
			for (j = 0; j < doc_bytes.size(); j++) begin
				steady = (random_sent >= 40 && random_sent < 90);
				feed(doc_bytes[j], doc_off, j == doc_bytes.size() - 1);
				random_sent++;
			end
		end
		steady = 1'b0;
		text_ch.valid <= 1'b0;

		while (want_posts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/tthi_pkg.sv
hdl/tthi_if.sv
hdl/tthi_front.sv
hdl/tthi_fifo.sv
hdl/tthi_back.sv
hdl/text_token_hash_indexer.sv
test/tb.sv
